[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

[src/ivs_pkg.sv]
// ----------------------------------------------------------------------------
// ivs_pkg
// shared types and constants of the interval value spread block
// ----------------------------------------------------------------------------
package ivs_pkg;

  localparam int FINE_ROWS   = 64;
  localparam int PERIOD_ROWS = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam int FINE_IDX_W  = $clog2(FINE_ROWS);
  localparam int FINE_CNT_W  = $clog2(FINE_ROWS + 1);
  localparam int PER_IDX_W   = $clog2(PERIOD_ROWS);
  localparam int PER_CNT_W   = $clog2(PERIOD_ROWS + 1);
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int TIME_W   = 32;
  localparam int VALUE_W  = 7;
  localparam int LENGTH_W = 20;
  localparam int SPREAD_W = 8;
  localparam int ROW_W    = 6;

  localparam logic [FINE_CNT_W-1:0]  FINE_FULL   = FINE_CNT_W'(FINE_ROWS);
  localparam logic [PER_CNT_W-1:0]   PERIOD_FULL = PER_CNT_W'(PERIOD_ROWS);
  localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL  = QUEUE_CNT_W'(QUEUE_DEPTH);

  localparam logic [LENGTH_W-1:0] PERIOD_LENGTH_RESET = 20'd43200;
  localparam logic [SPREAD_W-1:0] NO_SPREAD           = 8'hFF;

  typedef enum logic [1:0] {
    CMD_LOAD_FINE   = 2'd0,
    CMD_LOAD_PERIOD = 2'd1,
    CMD_RUN         = 2'd2,
    CMD_NONE        = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [TIME_W-1:0]   time_value;
    logic [VALUE_W-1:0]  period_value;
  } ivs_item_t;

  typedef struct packed {
    logic                last_row;
    logic [SPREAD_W-1:0] spread_value;
    logic [ROW_W-1:0]    row_index;
  } ivs_result_t;

endpackage

[src/ivs_front.sv]
// ----------------------------------------------------------------------------
// ivs_front
// accepts input items, drops unused commands, queues the rest for the back end
// ----------------------------------------------------------------------------
module ivs_front import ivs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ivs_item_t in_item,
  output logic      q_valid,
  input  logic      q_ready,
  output ivs_item_t q_item
);

  ivs_item_t               slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr;
  logic [QUEUE_PTR_W-1:0]  rd_ptr;
  logic [QUEUE_CNT_W-1:0]  count;
  logic                    push;
  logic                    pop;

  assign in_ready = (count != QUEUE_FULL);
  assign push     = in_valid && in_ready && (in_item.cmd != CMD_NONE);
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/ivs_back.sv]
// ----------------------------------------------------------------------------
// ivs_back
// table storage, range searches and row emission sequencer
// ----------------------------------------------------------------------------
module ivs_back import ivs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [LENGTH_W-1:0] period_length,
  input  logic                q_valid,
  output logic                q_ready,
  input  ivs_item_t           q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ivs_result_t         out_result
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SS_RD,
    ST_SS_CMP,
    ST_ES_RD,
    ST_ES_CMP,
    ST_EM_RD,
    ST_EM_CMP,
    ST_EM_OUT
  } state_t;

  state_t                 st;
  logic [TIME_W-1:0]      fine_mem [FINE_ROWS];
  logic [TIME_W-1:0]      end_mem  [PERIOD_ROWS];
  logic [VALUE_W-1:0]     val_mem  [PERIOD_ROWS];
  logic [TIME_W-1:0]      fine_q;
  logic [TIME_W-1:0]      end_q;
  logic [VALUE_W-1:0]     val_q;

  logic [FINE_CNT_W-1:0]  fine_count;
  logic [PER_CNT_W-1:0]   period_count;
  logic [FINE_IDX_W-1:0]  r;
  logic [PER_IDX_W-1:0]   p;
  logic [PER_IDX_W-1:0]   pidx;
  logic [FINE_IDX_W-1:0]  start;
  logic [FINE_IDX_W-1:0]  stop;
  logic                   found;
  logic                   have_end;
  logic                   in_range;

  logic                   fine_we;
  logic                   per_we;
  logic [FINE_IDX_W-1:0]  last_fine;
  logic [PER_IDX_W-1:0]   last_per;
  logic [PER_IDX_W-1:0]   pidx_inc;
  logic [PER_IDX_W-1:0]   end_addr;
  logic [PER_IDX_W-1:0]   val_addr;
  logic                   cover_c;
  logic                   in_range_c;
  logic                   adv_c;
  logic                   out_free;
  logic                   emit;

  assign q_ready   = (st == ST_IDLE);
  assign fine_we   = (st == ST_IDLE) && q_valid && (q_item.cmd == CMD_LOAD_FINE)
                     && (fine_count < FINE_FULL);
  assign per_we    = (st == ST_IDLE) && q_valid && (q_item.cmd == CMD_LOAD_PERIOD)
                     && (period_count < PERIOD_FULL);
  assign last_fine = FINE_IDX_W'(fine_count - 1'b1);
  assign last_per  = PER_IDX_W'(period_count - 1'b1);
  assign pidx_inc  = pidx + 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign emit      = (st == ST_EM_OUT) && out_free;

  // period covers t when end - length <= t <= end
  assign cover_c = (({1'b0, fine_q} + (TIME_W + 1)'(period_length)) >= {1'b0, end_q})
                   && (fine_q <= end_q);
  assign in_range_c = found && have_end && (r >= start) && (r <= stop);
  assign adv_c      = (fine_q > end_q) && ((PER_CNT_W'(pidx) + 1'b1) < period_count);

  always_comb begin
    unique case (st)
      ST_SS_RD: end_addr = p;
      ST_ES_RD: end_addr = last_per;
      default:  end_addr = pidx;
    endcase
    val_addr = ((st == ST_EM_CMP) && in_range_c && adv_c) ? pidx_inc : pidx;
  end

  always_ff @(posedge clk) begin
    if (fine_we) begin
      fine_mem[fine_count[FINE_IDX_W-1:0]] <= q_item.time_value;
    end
    fine_q <= fine_mem[r];
  end

  always_ff @(posedge clk) begin
    if (per_we) begin
      end_mem[period_count[PER_IDX_W-1:0]] <= q_item.time_value;
      val_mem[period_count[PER_IDX_W-1:0]] <= q_item.period_value;
    end
    end_q <= end_mem[end_addr];
    val_q <= val_mem[val_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_IDLE;
      fine_count   <= '0;
      period_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (q_valid) begin
            unique case (q_item.cmd)
              CMD_LOAD_FINE: begin
                if (fine_we) begin
                  fine_count <= fine_count + 1'b1;
                end
              end
              CMD_LOAD_PERIOD: begin
                if (per_we) begin
                  period_count <= period_count + 1'b1;
                end
              end
              CMD_RUN: begin
                r        <= '0;
                p        <= '0;
                pidx     <= '0;
                found    <= 1'b0;
                have_end <= 1'b0;
                if (fine_count == '0) begin
                  period_count <= '0;
                end else if (period_count == '0) begin
                  st <= ST_EM_RD;
                end else begin
                  st <= ST_SS_RD;
                end
              end
              CMD_NONE: begin
              end
            endcase
          end
        end
        ST_SS_RD: begin
          st <= ST_SS_CMP;
        end
        ST_SS_CMP: begin
          if (cover_c) begin
            start <= r;
            pidx  <= p;
            found <= 1'b1;
            r     <= last_fine;
            st    <= ST_ES_RD;
          end else if (r == last_fine) begin
            r <= '0;
            if (p == last_per) begin
              st <= ST_EM_RD;
            end else begin
              p  <= p + 1'b1;
              st <= ST_SS_RD;
            end
          end else begin
            r  <= r + 1'b1;
            st <= ST_SS_RD;
          end
        end
        ST_ES_RD: begin
          st <= ST_ES_CMP;
        end
        ST_ES_CMP: begin
          if (fine_q <= end_q) begin
            stop     <= r;
            have_end <= 1'b1;
            r        <= '0;
            st       <= ST_EM_RD;
          end else if (r == '0) begin
            st <= ST_EM_RD;
          end else begin
            r  <= r - 1'b1;
            st <= ST_ES_RD;
          end
        end
        ST_EM_RD: begin
          st <= ST_EM_CMP;
        end
        ST_EM_CMP: begin
          in_range <= in_range_c;
          if (in_range_c && adv_c) begin
            pidx <= pidx_inc;
          end
          st <= ST_EM_OUT;
        end
        ST_EM_OUT: begin
          if (out_free) begin
            out_result.row_index    <= ROW_W'(r);
            out_result.spread_value <= in_range ? {1'b0, val_q} : NO_SPREAD;
            out_result.last_row     <= (r == last_fine);
            if (r == last_fine) begin
              fine_count   <= '0;
              period_count <= '0;
              st           <= ST_IDLE;
            end else begin
              r  <= r + 1'b1;
              st <= ST_EM_RD;
            end
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[src/interval_value_spread.sv]
// ----------------------------------------------------------------------------
// interval_value_spread
// spreads period values over sorted fine times inside the covered range
// ----------------------------------------------------------------------------
// usage:
//   s_* carries items: tuser holds the command (load fine time, load period
//   entry, run), tdata the time and the period value. loads produce nothing;
//   a run emits one item per loaded fine row on m_*, tlast on the final row,
//   then clears both row counts. cfg_* writes the period length; the user
//   must do so only while idle, as the block itself does not enforce it.
//   a load is taken from the queue. a run visits ST_SS_RD and ST_SS_CMP per
//   (period, row) pair in the start search, ST_ES_RD and ST_ES_CMP per row
//   in the end search, then ST_EM_RD, ST_EM_CMP and ST_EM_OUT per emitted row.
//   every step waits on a registered read of the single-port table memories.
//   a four-entry queue lets loads and runs be taken while a run is busy.
// reset:
//   rst clears the queue, both row counts and the output stage, and sets the
//   period length to 43200 seconds. table contents are kept.
// stall:
//   when an output item waits and m_tready is low the emitter holds; once
//   the queue fills s_tready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module interval_value_spread import ivs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // time_value, period_value, zero pad
  input  logic [1:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // row_index, spread_value, zero pad
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data
);

  logic [LENGTH_W-1:0] period_length;
  ivs_item_t           in_item;
  ivs_item_t           q_item;
  logic                q_valid;
  logic                q_ready;
  ivs_result_t         result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_length <= PERIOD_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      period_length <= cfg_data;
    end
  end

  assign in_item.cmd          = cmd_t'(s_tuser);
  assign in_item.time_value   = s_tdata[TIME_W-1:0];
  assign in_item.period_value = s_tdata[TIME_W+VALUE_W-1:TIME_W];

  ivs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  ivs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .period_length (period_length),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_result    (result)
  );

  assign m_tdata = {2'b00, result.spread_value, result.row_index};
  assign m_tlast = result.last_row;

  // unused commands never reach the back end
  `ASSERT_IMPLIES(a_no_unused_cmd, clk, rst, q_valid && q_ready, q_item.cmd != CMD_NONE)
  // a stalled output item holds until it is taken
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  // the back end pulls no queue item while a run is still emitting
  `ASSERT_IMPLIES(a_no_pop_mid_run, clk, rst, q_ready && m_tvalid && !m_tready, m_tlast)

endmodule
